// ===== rtl/ndt_pkg.sv =====
package ndt_pkg;

    localparam int VERTEX_DEPTH = 4096;
    localparam int UNIQUE_DEPTH = 1024;
    localparam int COMP_W       = 16;

    localparam int VTX_AW   = $clog2(VERTEX_DEPTH);
    localparam int UNQ_AW   = $clog2(UNIQUE_DEPTH);
    localparam int FILL_W   = UNQ_AW + 1;
    localparam int VIDX_W   = 16;
    localparam int OP_W     = 2;
    localparam int VCNT_W   = 13;
    localparam int TOL_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IW   = 1;
    localparam int SUM_W    = COMP_W + 3;

    localparam logic [TOL_W-1:0]  TOL_RESET   = TOL_W'(3);
    localparam logic [CFG_IW-1:0] CFG_VCOUNT  = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] CFG_TOL     = CFG_IW'(1);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_CORNER = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SEARCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
    } t_norm;

    typedef struct packed {
        logic wr_vertex;
        logic clear;
        logic start;
        logic fetch;
        logic take_oor;
        logic search;
        logic finish_hit;
        logic finish_miss;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic oor;
        logic hit;
        logic miss_end;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/ndt_ctrl.sv =====
module ndt_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [ndt_pkg::OP_W-1:0]      i_operation,
    input  ndt_pkg::t_stat                i_stat,
    output logic                          o_in_ready,
    output ndt_pkg::t_cmd                 o_cmd
);

    ndt_pkg::t_state r_state;
    ndt_pkg::t_state n_state;
    ndt_pkg::t_op    w_op;

    assign w_op = ndt_pkg::t_op'(i_operation);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ndt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ndt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (w_op)
                        ndt_pkg::OP_LOAD:   o_cmd.wr_vertex = 1'b1;
                        ndt_pkg::OP_CLEAR:  o_cmd.clear = 1'b1;
                        ndt_pkg::OP_CORNER: begin
                            o_cmd.start = 1'b1;
                            n_state     = ndt_pkg::S_FETCH;
                        end
                        ndt_pkg::OP_NOP:    ;
                        default:            ;
                    endcase
                end
            end
            ndt_pkg::S_FETCH: begin
                // vertex normal arrives from the store this cycle
                o_cmd.fetch = 1'b1;
                if (i_stat.oor) begin
                    o_cmd.take_oor = 1'b1;
                    n_state        = ndt_pkg::S_DONE;
                end else begin
                    n_state = ndt_pkg::S_SEARCH;
                end
            end
            ndt_pkg::S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.finish_hit = 1'b1;
                    n_state          = ndt_pkg::S_DONE;
                end else if (i_stat.miss_end) begin
                    o_cmd.finish_miss = 1'b1;
                    n_state           = ndt_pkg::S_DONE;
                end
            end
            ndt_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ndt_pkg::S_IDLE;
                end
            end
            default: n_state = ndt_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== rtl/ndt_dp.sv =====
module ndt_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ndt_pkg::t_cmd                       i_cmd,
    output ndt_pkg::t_stat                      o_stat,
    input  logic                                i_cfg_wr_en,
    input  logic [ndt_pkg::CFG_IW-1:0]          i_cfg_index,
    input  logic [ndt_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic [ndt_pkg::VIDX_W-1:0]          i_vertex_index,
    input  logic signed [ndt_pkg::COMP_W-1:0]   i_normal_x,
    input  logic signed [ndt_pkg::COMP_W-1:0]   i_normal_y,
    input  logic signed [ndt_pkg::COMP_W-1:0]   i_normal_z,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [ndt_pkg::UNQ_AW-1:0]          o_unique_index,
    output logic                                o_is_new,
    output logic                                o_out_of_range,
    output logic                                o_table_full,
    output logic signed [ndt_pkg::COMP_W-1:0]   o_entry_x,
    output logic signed [ndt_pkg::COMP_W-1:0]   o_entry_y,
    output logic signed [ndt_pkg::COMP_W-1:0]   o_entry_z,
    output logic [ndt_pkg::FILL_W-1:0]          o_unique_total
);

    // configuration
    logic [ndt_pkg::VCNT_W-1:0] r_vertex_count;
    logic [ndt_pkg::TOL_W-1:0]  r_match_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_match_tol    <= ndt_pkg::TOL_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == ndt_pkg::CFG_VCOUNT) begin
                r_vertex_count <= i_cfg_wdata[ndt_pkg::VCNT_W-1:0];
            end else if (i_cfg_index == ndt_pkg::CFG_TOL) begin
                r_match_tol <= i_cfg_wdata[ndt_pkg::TOL_W-1:0];
            end
        end
    end

    // vertex normal store
    ndt_pkg::t_norm                  r_vtx_mem [ndt_pkg::VERTEX_DEPTH];
    ndt_pkg::t_norm                  r_vtx_rd;
    logic [ndt_pkg::VTX_AW-1:0]      w_vtx_addr;
    logic                            w_in_store;
    logic                            w_oor;

    assign w_vtx_addr = i_vertex_index[ndt_pkg::VTX_AW-1:0];
    assign w_in_store = 32'(i_vertex_index) < 32'(ndt_pkg::VERTEX_DEPTH);
    assign w_oor      = !w_in_store || !(32'(i_vertex_index) < 32'(r_vertex_count));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_vertex && w_in_store) begin
            r_vtx_mem[w_vtx_addr] <= '{x: i_normal_x, y: i_normal_y, z: i_normal_z};
        end
        if (i_cmd.start) begin
            r_vtx_rd <= r_vtx_mem[w_vtx_addr];
        end
    end

    // search control
    logic [ndt_pkg::FILL_W-1:0] r_fill;
    logic [ndt_pkg::FILL_W-1:0] r_rd_idx;
    logic [ndt_pkg::UNQ_AW-1:0] r_cmp_idx;
    logic                       r_cmp_vld;
    logic                       r_oor;
    ndt_pkg::t_norm             r_norm;
    logic                       w_rd_en;
    logic                       w_full;
    logic                       w_append;

    assign w_rd_en  = i_cmd.search && (r_rd_idx < r_fill);
    assign w_full   = r_fill == ndt_pkg::FILL_W'(ndt_pkg::UNIQUE_DEPTH);
    assign w_append = i_cmd.finish_miss && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_oor     <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_fill <= '0;
            end else if (w_append) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.start) begin
                r_oor     <= w_oor;
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.search) begin
                r_cmp_vld <= w_rd_en;
                if (w_rd_en) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_norm <= r_vtx_rd;
        end
        if (w_rd_en) begin
            r_cmp_idx <= r_rd_idx[ndt_pkg::UNQ_AW-1:0];
        end
    end

    // unique table
    ndt_pkg::t_norm r_unq_mem [ndt_pkg::UNIQUE_DEPTH];
    ndt_pkg::t_norm r_unq_rd;

    always_ff @(posedge i_clk) begin
        if (w_append) begin
            r_unq_mem[r_fill[ndt_pkg::UNQ_AW-1:0]] <= r_norm;
        end
        if (w_rd_en) begin
            r_unq_rd <= r_unq_mem[r_rd_idx[ndt_pkg::UNQ_AW-1:0]];
        end
    end

    // summed absolute difference against the entry just read
    logic signed [ndt_pkg::COMP_W:0] w_dx;
    logic signed [ndt_pkg::COMP_W:0] w_dy;
    logic signed [ndt_pkg::COMP_W:0] w_dz;
    logic [ndt_pkg::COMP_W:0]        w_ax;
    logic [ndt_pkg::COMP_W:0]        w_ay;
    logic [ndt_pkg::COMP_W:0]        w_az;
    logic [ndt_pkg::SUM_W-1:0]       w_sum;

    always_comb begin
        w_dx  = {r_norm.x[ndt_pkg::COMP_W-1], r_norm.x}
              - {r_unq_rd.x[ndt_pkg::COMP_W-1], r_unq_rd.x};
        w_dy  = {r_norm.y[ndt_pkg::COMP_W-1], r_norm.y}
              - {r_unq_rd.y[ndt_pkg::COMP_W-1], r_unq_rd.y};
        w_dz  = {r_norm.z[ndt_pkg::COMP_W-1], r_norm.z}
              - {r_unq_rd.z[ndt_pkg::COMP_W-1], r_unq_rd.z};
        w_ax  = w_dx[ndt_pkg::COMP_W] ? $unsigned(-w_dx) : $unsigned(w_dx);
        w_ay  = w_dy[ndt_pkg::COMP_W] ? $unsigned(-w_dy) : $unsigned(w_dy);
        w_az  = w_dz[ndt_pkg::COMP_W] ? $unsigned(-w_dz) : $unsigned(w_dz);
        w_sum = ndt_pkg::SUM_W'(w_ax) + ndt_pkg::SUM_W'(w_ay) + ndt_pkg::SUM_W'(w_az);
    end

    assign o_stat.oor      = r_oor;
    assign o_stat.hit      = r_cmp_vld && (w_sum < ndt_pkg::SUM_W'(r_match_tol));
    assign o_stat.miss_end = !r_cmp_vld && (r_rd_idx == r_fill);
    assign o_stat.out_free = !o_out_valid || i_out_ready;

    // pending result
    logic [ndt_pkg::UNQ_AW-1:0] r_res_idx;
    logic                       r_res_new;
    logic                       r_res_oor;
    logic                       r_res_full;
    ndt_pkg::t_norm             r_res_entry;
    logic [ndt_pkg::FILL_W-1:0] r_res_total;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_oor) begin
            r_res_idx   <= '0;
            r_res_new   <= 1'b0;
            r_res_oor   <= 1'b1;
            r_res_full  <= 1'b0;
            r_res_entry <= '0;
            r_res_total <= r_fill;
        end else if (i_cmd.finish_hit) begin
            r_res_idx   <= r_cmp_idx;
            r_res_new   <= 1'b0;
            r_res_oor   <= 1'b0;
            r_res_full  <= 1'b0;
            r_res_entry <= r_unq_rd;
            r_res_total <= r_fill;
        end else if (i_cmd.finish_miss) begin
            r_res_oor <= 1'b0;
            if (w_full) begin
                r_res_idx   <= '0;
                r_res_new   <= 1'b0;
                r_res_full  <= 1'b1;
                r_res_entry <= '0;
                r_res_total <= r_fill;
            end else begin
                r_res_idx   <= r_fill[ndt_pkg::UNQ_AW-1:0];
                r_res_new   <= 1'b1;
                r_res_full  <= 1'b0;
                r_res_entry <= r_norm;
                r_res_total <= r_fill + 1'b1;
            end
        end
    end

    // output register
    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_unique_index <= r_res_idx;
            o_is_new       <= r_res_new;
            o_out_of_range <= r_res_oor;
            o_table_full   <= r_res_full;
            o_entry_x      <= r_res_entry.x;
            o_entry_y      <= r_res_entry.y;
            o_entry_z      <= r_res_entry.z;
            o_unique_total <= r_res_total;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

// ===== rtl/normal_dedup_with_tolerance.sv =====
// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     operation, vertex index, normal x y z
// out       output     o_out_valid / i_out_ready   unique index, flags, entry x y z, total
// cfg       input      i_cfg_wr_en                 i_cfg_index, i_cfg_wdata
//
// load, clear and no-op items are taken in the idle state, which they do not leave.
// a corner item goes through the store fetch, then reads one unique table entry
// per cycle from the single table read port, then passes the result stage; a
// search ends on the first hit or once every filled entry has been compared.
// one item is worked at a time; a result waiting in the output register does
// not block the next item until that item's own result is ready.
// reset is synchronous, active low; both stores come up undefined and the
// unique table is empty.
module normal_dedup_with_tolerance (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ndt_pkg::CFG_IW-1:0]          i_cfg_index,
    input  logic [ndt_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [ndt_pkg::OP_W-1:0]            i_operation,
    input  logic [ndt_pkg::VIDX_W-1:0]          i_vertex_index,
    input  logic signed [ndt_pkg::COMP_W-1:0]   i_normal_x,
    input  logic signed [ndt_pkg::COMP_W-1:0]   i_normal_y,
    input  logic signed [ndt_pkg::COMP_W-1:0]   i_normal_z,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ndt_pkg::UNQ_AW-1:0]          o_unique_index,
    output logic                                o_is_new,
    output logic                                o_out_of_range,
    output logic                                o_table_full,
    output logic signed [ndt_pkg::COMP_W-1:0]   o_entry_x,
    output logic signed [ndt_pkg::COMP_W-1:0]   o_entry_y,
    output logic signed [ndt_pkg::COMP_W-1:0]   o_entry_z,
    output logic [ndt_pkg::FILL_W-1:0]          o_unique_total
);

    ndt_pkg::t_cmd  w_cmd;
    ndt_pkg::t_stat w_stat;

    ndt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (w_cmd)
    );

    ndt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_vertex_index (i_vertex_index),
        .i_normal_x     (i_normal_x),
        .i_normal_y     (i_normal_y),
        .i_normal_z     (i_normal_z),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_unique_index (o_unique_index),
        .o_is_new       (o_is_new),
        .o_out_of_range (o_out_of_range),
        .o_table_full   (o_table_full),
        .o_entry_x      (o_entry_x),
        .o_entry_y      (o_entry_y),
        .o_entry_z      (o_entry_z),
        .o_unique_total (o_unique_total)
    );

endmodule

// ===== rtl/ndt_chk.sv =====
module ndt_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [ndt_pkg::UNQ_AW-1:0]    o_unique_index,
    input  logic                          o_is_new,
    input  logic                          o_out_of_range,
    input  logic                          o_table_full,
    input  logic [ndt_pkg::FILL_W-1:0]    o_unique_total
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_unique_index)
            && $stable(o_unique_total))
        else $error("stalled result changed");

    // error results carry index 0 and never append
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_of_range || o_table_full) |->
            o_unique_index == '0 && !o_is_new && !(o_out_of_range && o_table_full))
        else $error("malformed error result");

    // an appended entry is the last one of the table
    a_new_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_new |->
            o_unique_total == ndt_pkg::FILL_W'(o_unique_index) + 1'b1)
        else $error("appended index not at end of table");

    a_hit_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_of_range && !o_table_full |->
            ndt_pkg::FILL_W'(o_unique_index) < o_unique_total)
        else $error("returned index beyond table fill");

endmodule

bind normal_dedup_with_tolerance ndt_chk u_ndt_chk (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SEGMENTS    = 12;
    localparam int SEG_ITEMS   = 46;
    localparam int FILL_CAP    = 40;

    typedef struct {
        logic [ndt_pkg::UNQ_AW-1:0] idx;
        logic                       is_new;
        logic                       oor;
        logic                       full;
        ndt_pkg::t_norm             entry;
        logic [ndt_pkg::FILL_W-1:0] total;
    } t_weld_result;

    class weld_scoreboard;
        ndt_pkg::t_norm             vtx_store [ndt_pkg::VERTEX_DEPTH];
        ndt_pkg::t_norm             uniq_table [ndt_pkg::UNIQUE_DEPTH];
        int                         fill;
        logic [ndt_pkg::VCNT_W-1:0] vcount;
        logic [ndt_pkg::TOL_W-1:0]  tol;
        t_weld_result               pending_welds [$];
        int                         errors;
        int                         n_checked;
        int                         n_new;
        int                         n_hit;
        int                         n_oor;
        int                         n_full;

        function new();
            fill      = 0;
            vcount    = '0;
            tol       = ndt_pkg::TOL_RESET;
            errors    = 0;
            n_checked = 0;
            n_new     = 0;
            n_hit     = 0;
            n_oor     = 0;
            n_full    = 0;
        endfunction

        function void write_reg(logic [ndt_pkg::CFG_IW-1:0] idx,
                                logic [ndt_pkg::CFG_W-1:0] val);
            if (idx == ndt_pkg::CFG_VCOUNT) begin
                vcount = val[ndt_pkg::VCNT_W-1:0];
            end else if (idx == ndt_pkg::CFG_TOL) begin
                tol = val[ndt_pkg::TOL_W-1:0];
            end
        endfunction

        function int comp_gap(logic signed [ndt_pkg::COMP_W-1:0] a,
                              logic signed [ndt_pkg::COMP_W-1:0] b);
            int d;
            d = int'(a) - int'(b);
            return (d < 0) ? -d : d;
        endfunction

        function int normal_gap(ndt_pkg::t_norm a, ndt_pkg::t_norm b);
            return comp_gap(a.x, b.x) + comp_gap(a.y, b.y) + comp_gap(a.z, b.z);
        endfunction

        function t_weld_result weld_corner(logic [ndt_pkg::VIDX_W-1:0] vi);
            t_weld_result   r;
            ndt_pkg::t_norm v;
            int             i;
            r.idx    = '0;
            r.is_new = 1'b0;
            r.oor    = 1'b0;
            r.full   = 1'b0;
            r.entry  = '0;
            r.total  = ndt_pkg::FILL_W'(fill);
            if (vi >= vcount || vi >= ndt_pkg::VERTEX_DEPTH) begin
                r.oor = 1'b1;
                n_oor++;
                return r;
            end
            v = vtx_store[vi[ndt_pkg::VTX_AW-1:0]];
            // first entry strictly inside the tolerance wins
            for (i = 0; i < fill; i++) begin
                if (normal_gap(v, uniq_table[i]) < int'(tol)) begin
                    r.idx   = ndt_pkg::UNQ_AW'(i);
                    r.entry = uniq_table[i];
                    n_hit++;
                    return r;
                end
            end
            if (fill >= ndt_pkg::UNIQUE_DEPTH) begin
                r.full = 1'b1;
                n_full++;
                return r;
            end
            uniq_table[fill] = v;
            r.idx    = ndt_pkg::UNQ_AW'(fill);
            r.is_new = 1'b1;
            r.entry  = v;
            fill++;
            r.total  = ndt_pkg::FILL_W'(fill);
            n_new++;
            return r;
        endfunction

        function void note_item(ndt_pkg::t_op op, logic [ndt_pkg::VIDX_W-1:0] vi,
                                ndt_pkg::t_norm n);
            case (op)
                ndt_pkg::OP_LOAD: begin
                    if (vi < ndt_pkg::VERTEX_DEPTH) vtx_store[vi[ndt_pkg::VTX_AW-1:0]] = n;
                end
                ndt_pkg::OP_CLEAR: begin
                    fill = 0;
                end
                ndt_pkg::OP_CORNER: begin
                    pending_welds.insert(pending_welds.size(), weld_corner(vi));
                end
                default: begin
                end
            endcase
        endfunction

        function void same(string what, logic signed [31:0] want_v,
                           logic signed [31:0] got_v);
            if (want_v !== got_v) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(t_weld_result got);
            t_weld_result want;
            if (pending_welds.size() == 0) begin
                $display("%0t: result with no corner waiting, index %0d", $time, got.idx);
                errors++;
                return;
            end
            want = pending_welds.pop_front();
            n_checked++;
            same("unique_index", want.idx, got.idx);
            same("is_new", want.is_new, got.is_new);
            same("out_of_range", want.oor, got.oor);
            same("table_full", want.full, got.full);
            same("entry_x", want.entry.x, got.entry.x);
            same("entry_y", want.entry.y, got.entry.y);
            same("entry_z", want.entry.z, got.entry.z);
            same("unique_total", want.total, got.total);
        endfunction
    endclass

    logic                              i_clk          = 1'b0;
    logic                              i_rst_n        = 1'b0;
    logic                              i_cfg_wr_en    = 1'b0;
    logic [ndt_pkg::CFG_IW-1:0]        i_cfg_index    = '0;
    logic [ndt_pkg::CFG_W-1:0]         i_cfg_wdata    = '0;
    logic                              i_in_valid     = 1'b0;
    logic                              o_in_ready;
    logic [ndt_pkg::OP_W-1:0]          i_operation    = '0;
    logic [ndt_pkg::VIDX_W-1:0]        i_vertex_index = '0;
    logic signed [ndt_pkg::COMP_W-1:0] i_normal_x     = '0;
    logic signed [ndt_pkg::COMP_W-1:0] i_normal_y     = '0;
    logic signed [ndt_pkg::COMP_W-1:0] i_normal_z     = '0;
    logic                              o_out_valid;
    logic                              i_out_ready    = 1'b0;
    logic [ndt_pkg::UNQ_AW-1:0]        o_unique_index;
    logic                              o_is_new;
    logic                              o_out_of_range;
    logic                              o_table_full;
    logic signed [ndt_pkg::COMP_W-1:0] o_entry_x;
    logic signed [ndt_pkg::COMP_W-1:0] o_entry_y;
    logic signed [ndt_pkg::COMP_W-1:0] o_entry_z;
    logic [ndt_pkg::FILL_W-1:0]        o_unique_total;

    weld_scoreboard sb;
    int             idle_pct    = 0;
    int             stall_pct   = 0;
    int             items_sent  = 0;
    int             cycle_count = 0;
    bit             vtx_loaded [ndt_pkg::VERTEX_DEPTH];
    int             loaded_list [$];

    // negative tolerance entry picks a random tolerance
    int seg_vcount [SEGMENTS] = '{16, 64, 4096, 65535, 0, 40, 64, 4096, 1, 32, 64, 4096};
    int seg_tol    [SEGMENTS] = '{3, 0, 8, 20, 1, 65535, -1, 12, 3, 0, 6, 65535};

    normal_dedup_with_tolerance dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_vertex_index (i_vertex_index),
        .i_normal_x     (i_normal_x),
        .i_normal_y     (i_normal_y),
        .i_normal_z     (i_normal_z),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_unique_index (o_unique_index),
        .o_is_new       (o_is_new),
        .o_out_of_range (o_out_of_range),
        .o_table_full   (o_table_full),
        .o_entry_x      (o_entry_x),
        .o_entry_y      (o_entry_y),
        .o_entry_z      (o_entry_z),
        .o_unique_total (o_unique_total)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_weld_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.idx    = o_unique_index;
            got.is_new = o_is_new;
            got.oor    = o_out_of_range;
            got.full   = o_table_full;
            got.entry  = {o_entry_x, o_entry_y, o_entry_z};
            got.total  = o_unique_total;
            sb.check_result(got);
        end
    end

    function automatic ndt_pkg::t_norm base_normal(int k);
        case (k)
            0:       return {16'h7fff, 16'h0000, 16'h0000};
            1:       return {16'h0000, 16'h8000, 16'h0000};
            2:       return {16'h0000, 16'h0000, 16'h7fff};
            3:       return {16'h8000, 16'h8000, 16'h8000};
            4:       return {16'h7fff, 16'h7fff, 16'h7fff};
            default: return {16'h5a82, 16'ha57e, 16'h0000};
        endcase
    endfunction

    // mostly small jitter around a few directions so welds actually hit
    function automatic ndt_pkg::t_norm pick_normal();
        ndt_pkg::t_norm n;
        ndt_pkg::t_norm b;
        if ($urandom_range(4) == 0) begin
            n.x = ndt_pkg::COMP_W'($urandom);
            n.y = ndt_pkg::COMP_W'($urandom);
            n.z = ndt_pkg::COMP_W'($urandom);
            return n;
        end
        b   = base_normal($urandom_range(5));
        n.x = b.x + ndt_pkg::COMP_W'($urandom_range(6)) - ndt_pkg::COMP_W'(3);
        n.y = b.y + ndt_pkg::COMP_W'($urandom_range(6)) - ndt_pkg::COMP_W'(3);
        n.z = b.z + ndt_pkg::COMP_W'($urandom_range(6)) - ndt_pkg::COMP_W'(3);
        return n;
    endfunction

    // never names a vertex below the count that was never loaded
    function automatic logic [ndt_pkg::VIDX_W-1:0] pick_corner_vertex(bit want_loaded);
        int lim;
        int v;
        int k;
        lim = (sb.vcount < ndt_pkg::VERTEX_DEPTH) ? int'(sb.vcount) : ndt_pkg::VERTEX_DEPTH;
        if (want_loaded && loaded_list.size() > 0) begin
            for (k = 0; k < 16; k++) begin
                v = loaded_list[$urandom_range(loaded_list.size() - 1)];
                if (v < lim) return ndt_pkg::VIDX_W'(v);
            end
        end
        return ndt_pkg::VIDX_W'($urandom_range(65535, lim));
    endfunction

    task automatic set_phase(input int p);
        case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 69; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 69; end
            default: begin idle_pct = 13; stall_pct = 13; end
        endcase
    endtask

    task automatic send_item(input ndt_pkg::t_op op, input logic [ndt_pkg::VIDX_W-1:0] vi,
                             input ndt_pkg::t_norm n);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_vertex_index <= vi;
        i_normal_x     <= n.x;
        i_normal_y     <= n.y;
        i_normal_z     <= n.z;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(op, vi, n);
        items_sent++;
        if (op == ndt_pkg::OP_LOAD && vi < ndt_pkg::VERTEX_DEPTH
                && !vtx_loaded[vi[ndt_pkg::VTX_AW-1:0]]) begin
            vtx_loaded[vi[ndt_pkg::VTX_AW-1:0]] = 1'b1;
            loaded_list.insert(loaded_list.size(), int'(vi));
        end
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending_welds.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ndt_pkg::CFG_IW-1:0] idx,
                             input logic [ndt_pkg::CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int                         s;
        int                         k;
        int                         r;
        logic [ndt_pkg::VIDX_W-1:0] vi;
        sb = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_phase(0);

        // count is zero out of reset, so any corner is out of range
        send_item(ndt_pkg::OP_CORNER, 16'd0, '0);
        wait_idle();
        write_reg(ndt_pkg::CFG_VCOUNT, 16'd16);
        send_item(ndt_pkg::OP_LOAD, 16'd0, {16'h7fff, 16'h7fff, 16'h7fff});
        send_item(ndt_pkg::OP_LOAD, 16'd1, {16'h8000, 16'h8000, 16'h8000});
        send_item(ndt_pkg::OP_LOAD, 16'd2, {16'h7ffe, 16'h7fff, 16'h7fff});
        send_item(ndt_pkg::OP_LOAD, 16'd3, {16'h0000, 16'h0000, 16'h0000});
        send_item(ndt_pkg::OP_LOAD, 16'd4, {16'h7fff, 16'h7fff, 16'h7ffc});
        // loads past the vertex store are dropped
        send_item(ndt_pkg::OP_LOAD, 16'd4096, {16'h1234, 16'h5678, 16'h9abc});
        send_item(ndt_pkg::OP_LOAD, 16'hffff, {16'hffff, 16'hffff, 16'hffff});
        send_item(ndt_pkg::OP_NOP, 16'hffff, {16'hffff, 16'hffff, 16'hffff});
        send_item(ndt_pkg::OP_CORNER, 16'd0, '0);
        send_item(ndt_pkg::OP_CORNER, 16'd1, '0);
        send_item(ndt_pkg::OP_CORNER, 16'd2, '0);
        // gap of exactly the tolerance must not weld
        send_item(ndt_pkg::OP_CORNER, 16'd4, '0);
        send_item(ndt_pkg::OP_CORNER, 16'd3, '0);
        send_item(ndt_pkg::OP_CORNER, 16'd0, '0);
        send_item(ndt_pkg::OP_CORNER, 16'd16, '0);
        send_item(ndt_pkg::OP_CORNER, 16'hffff, '0);
        send_item(ndt_pkg::OP_CLEAR, 16'd0, '0);
        send_item(ndt_pkg::OP_CORNER, 16'd2, '0);
        send_item(ndt_pkg::OP_CORNER, 16'd0, '0);

        // zero tolerance never welds, not even the same normal twice
        wait_idle();
        write_reg(ndt_pkg::CFG_TOL, 16'd0);
        send_item(ndt_pkg::OP_CLEAR, 16'd0, pick_normal());
        for (k = 0; k < 8; k++) begin
            send_item(ndt_pkg::OP_CORNER, ndt_pkg::VIDX_W'(k % 5), pick_normal());
        end
        wait_idle();
        write_reg(ndt_pkg::CFG_TOL, 16'hffff);
        send_item(ndt_pkg::OP_CORNER, 16'd3, pick_normal());
        send_item(ndt_pkg::OP_CORNER, 16'd0, pick_normal());
        send_item(ndt_pkg::OP_CORNER, 16'd1, pick_normal());
        send_item(ndt_pkg::OP_CLEAR, 16'd0, pick_normal());

        for (s = 0; s < SEGMENTS; s++) begin
            wait_idle();
            set_phase(s % 4);
            write_reg(ndt_pkg::CFG_VCOUNT, ndt_pkg::CFG_W'(seg_vcount[s]));
            if (seg_tol[s] < 0) begin
                write_reg(ndt_pkg::CFG_TOL, ndt_pkg::CFG_W'($urandom_range(65535)));
            end else begin
                write_reg(ndt_pkg::CFG_TOL, ndt_pkg::CFG_W'(seg_tol[s]));
            end
            for (k = 0; k < SEG_ITEMS; k++) begin
                r = $urandom_range(99);
                if (r < 30) begin
                    if ($urandom_range(4) == 0) begin
                        vi = ndt_pkg::VIDX_W'($urandom);
                    end else begin
                        vi = ndt_pkg::VIDX_W'($urandom_range(63));
                    end
                    send_item(ndt_pkg::OP_LOAD, vi, pick_normal());
                end else if (r < 88) begin
                    // keep the search short
                    if (sb.fill >= FILL_CAP) begin
                        send_item(ndt_pkg::OP_CLEAR, ndt_pkg::VIDX_W'($urandom), pick_normal());
                    end
                    send_item(ndt_pkg::OP_CORNER, pick_corner_vertex($urandom_range(9) != 0),
                              pick_normal());
                end else if (r < 94) begin
                    send_item(ndt_pkg::OP_CLEAR, ndt_pkg::VIDX_W'($urandom), pick_normal());
                end else begin
                    send_item(ndt_pkg::OP_NOP, ndt_pkg::VIDX_W'($urandom), pick_normal());
                end
            end
        end

        wait_idle();
        repeat (ndt_pkg::UNIQUE_DEPTH + 16) @(negedge i_clk);
        $display("%0d items sent over %0d cycles, %0d corner results checked",
                 items_sent, cycle_count, sb.n_checked);
        $display("welds: %0d appended, %0d matched, %0d out of range, %0d table full",
                 sb.n_new, sb.n_hit, sb.n_oor, sb.n_full);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ndt_pkg.sv
rtl/ndt_ctrl.sv
rtl/ndt_dp.sv
rtl/normal_dedup_with_tolerance.sv
rtl/ndt_chk.sv
tb/sv/tb.sv
